### rtl/core/cgpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpg_pkg
// Shared types, constants and helper functions of the cylindrical grid point
// generator core.
// ----------------------------------------------------------------------------
package cgpg_pkg;

    localparam int MAX_POINTS    = 4096;
    localparam int FRACTION_BITS = 8;

    localparam int CFG_W      = 16;
    localparam int CNT_W      = 13;
    localparam int IDX_W      = 12;
    localparam int POS_W      = 24;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INNER_DIAMETER  = 3'd0,
        CFG_OUTER_DIAMETER  = 3'd1,
        CFG_CYLINDER_HEIGHT = 3'd2,
        CFG_CIRCLE_POINTS   = 3'd3,
        CFG_RADIAL_POINTS   = 3'd4,
        CFG_HEIGHT_POINTS   = 3'd5
    } t_cfg_addr;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    localparam int CORDIC_STEPS = 24;
    localparam int CORD_W       = 32;
    localparam int PHASE_W      = 32;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [PHASE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam int PRD_W   = CFG_W + CNT_W;
    localparam int STEP_W  = CFG_W + CNT_W + 2;
    localparam int A_W     = PRD_W + 3;
    localparam int R_NUM_W = 31 + FRACTION_BITS;
    localparam int R_DEN_W = CNT_W + 2;
    localparam int P_NUM_W = IDX_W + PHASE_W;
    localparam int P_DEN_W = CNT_W;
    localparam int Z_NUM_W = PRD_W + 1 + FRACTION_BITS;
    localparam int Z_DEN_W = CNT_W + 1;
    localparam int RAD_W   = 33;
    localparam int PROD_W  = RAD_W + CORD_W;

    localparam logic [RAD_W-1:0] RADIUS_LIMIT = 33'h0FFFFFFFF;
    localparam logic signed [PROD_W-1:0] S24_MAX = 8388607;
    localparam logic signed [PROD_W-1:0] S24_MIN = -8388608;
    localparam logic [Z_NUM_W-1:0] U24_MAX = Z_NUM_W'(24'hFFFFFF);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h20000000);

    localparam int LAT_FRONT  = 2;
    localparam int LAT_CORD   = CORDIC_STEPS + 1;
    localparam int T_CORD     = LAT_FRONT + P_NUM_W + LAT_CORD;
    localparam int PIPE_DEPTH = T_CORD + 2;
    localparam int R_DLY      = T_CORD - (LAT_FRONT + R_NUM_W + 1);
    localparam int Z_DLY      = PIPE_DEPTH - (LAT_FRONT + Z_NUM_W);

    typedef struct packed {
        logic [IDX_W-1:0] height_index;
        logic [IDX_W-1:0] radial_index;
        logic [IDX_W-1:0] angle_index;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic [POS_W-1:0]        z_pos;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] inner_diameter;
        logic [CFG_W-1:0] outer_diameter;
        logic [CFG_W-1:0] cylinder_height;
        logic [CNT_W-1:0] circle_cnt;
        logic [CNT_W-1:0] radial_cnt;
        logic [CNT_W-1:0] height_cnt;
    } t_cfg;

    function automatic logic [CNT_W-1:0] count_of(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0) begin
            res = CNT_W'(1);
        end else if (32'(v) > MAX_POINTS) begin
            res = CNT_W'(MAX_POINTS);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_s24(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] c;
        if (v > S24_MAX) begin
            c = S24_MAX;
        end else if (v < S24_MIN) begin
            c = S24_MIN;
        end else begin
            c = v;
        end
        return c[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_u24(input logic [Z_NUM_W-1:0] v);
        logic [POS_W-1:0] res;
        if (v > U24_MAX) begin
            res = '1;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/cylindrical_grid_point_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylindrical_grid_point_generator_core
// The core takes one index triple per clock while the pipeline is not frozen
// and returns the Cartesian center of that annular grid cell through 73
// pipeline stages plus the output register. The depth is set by the phase
// divider, which resolves one of its 44 quotient bits per stage, followed by
// the 24-step CORDIC, a multiply stage and a rounding stage. The pipeline
// freezes only when its last stage and the output register both hold results
// and the output is stalled. The user must write configuration registers only
// while no transfer is in flight; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module cylindrical_grid_point_generator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cgpg_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cgpg_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [cgpg_pkg::CFG_ADDR_W-1:0]   i_cfg_index,
    input  logic [cgpg_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int L       = cgpg_pkg::PIPE_DEPTH;
    localparam int CNT_W   = cgpg_pkg::CNT_W;
    localparam int CFG_W   = cgpg_pkg::CFG_W;
    localparam int RAD_W   = cgpg_pkg::RAD_W;
    localparam int PROD_W  = cgpg_pkg::PROD_W;
    localparam int POS_W   = cgpg_pkg::POS_W;
    localparam int RQ_W    = cgpg_pkg::R_NUM_W;
    localparam int CORD_W  = cgpg_pkg::CORD_W;

    logic [CFG_W-1:0] r_inner_diameter;
    logic [CFG_W-1:0] r_outer_diameter;
    logic [CFG_W-1:0] r_cylinder_height;
    logic [CNT_W-1:0] r_circle_points;
    logic [CNT_W-1:0] r_radial_points;
    logic [CNT_W-1:0] r_height_points;

    cgpg_pkg::t_cfg w_cfg;

    logic [L:1]       r_vld;
    logic             w_en;
    logic             r_out_valid;
    cgpg_pkg::t_out_item r_out_item;
    cgpg_pkg::t_out_item w_last;

    logic [RQ_W-1:0]                   w_r_mag;
    logic                              w_r_neg;
    logic [cgpg_pkg::R_DEN_W-1:0]      w_r_den;
    logic [cgpg_pkg::P_NUM_W-1:0]      w_p_num;
    logic [cgpg_pkg::P_DEN_W-1:0]      w_p_den;
    logic [cgpg_pkg::Z_NUM_W-1:0]      w_z_num;
    logic [cgpg_pkg::Z_DEN_W-1:0]      w_z_den;

    logic [RQ_W-1:0]                   w_rq;
    logic                              w_rq_nz;
    logic                              w_rq_neg;
    logic [RQ_W:0]                     w_rmag;
    logic [RAD_W-1:0]                  w_rclamp;
    logic signed [RAD_W-1:0]           r_radius;
    logic [RAD_W-1:0]                  w_radius_d;

    logic [cgpg_pkg::P_NUM_W-1:0]      w_pq;
    logic signed [CORD_W-1:0]          w_cos;
    logic signed [CORD_W-1:0]          w_sin;

    logic [cgpg_pkg::Z_NUM_W-1:0]      w_zq;
    logic [POS_W-1:0]                  w_zsat;
    logic [POS_W-1:0]                  w_z_d;

    logic signed [PROD_W-1:0]          r_px;
    logic signed [PROD_W-1:0]          r_py;
    logic signed [POS_W-1:0]           r_x;
    logic signed [POS_W-1:0]           r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_diameter  <= CFG_W'(0);
            r_outer_diameter  <= CFG_W'(1000);
            r_cylinder_height <= CFG_W'(1000);
            r_circle_points   <= CNT_W'(16);
            r_radial_points   <= CNT_W'(4);
            r_height_points   <= CNT_W'(4);
        end else if (i_cfg_we) begin
            case (cgpg_pkg::t_cfg_addr'(i_cfg_index))
                cgpg_pkg::CFG_INNER_DIAMETER:  r_inner_diameter  <= i_cfg_data;
                cgpg_pkg::CFG_OUTER_DIAMETER:  r_outer_diameter  <= i_cfg_data;
                cgpg_pkg::CFG_CYLINDER_HEIGHT: r_cylinder_height <= i_cfg_data;
                cgpg_pkg::CFG_CIRCLE_POINTS:   r_circle_points   <= i_cfg_data[CNT_W-1:0];
                cgpg_pkg::CFG_RADIAL_POINTS:   r_radial_points   <= i_cfg_data[CNT_W-1:0];
                cgpg_pkg::CFG_HEIGHT_POINTS:   r_height_points   <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.inner_diameter  = r_inner_diameter;
    assign w_cfg.outer_diameter  = r_outer_diameter;
    assign w_cfg.cylinder_height = r_cylinder_height;
    assign w_cfg.circle_cnt      = cgpg_pkg::count_of(r_circle_points);
    assign w_cfg.radial_cnt      = cgpg_pkg::count_of(r_radial_points);
    assign w_cfg.height_cnt      = cgpg_pkg::count_of(r_height_points);

    assign w_en       = !(r_vld[L] && r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-1:1], i_in_valid};
        end
    end

    cgpg_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_item  (i_in_item),
        .i_cfg   (w_cfg),
        .o_r_mag (w_r_mag),
        .o_r_neg (w_r_neg),
        .o_r_den (w_r_den),
        .o_p_num (w_p_num),
        .o_p_den (w_p_den),
        .o_z_num (w_z_num),
        .o_z_den (w_z_den)
    );

    cgpg_div #(
        .NUM_W  (RQ_W),
        .DEN_W  (cgpg_pkg::R_DEN_W),
        .SIDE_W (1)
    ) u_div_radius (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (w_r_mag),
        .i_den    (w_r_den),
        .i_side   (w_r_neg),
        .o_quo    (w_rq),
        .o_rem_nz (w_rq_nz),
        .o_side   (w_rq_neg)
    );

    assign w_rmag   = (RQ_W+1)'(w_rq) + (RQ_W+1)'(w_rq_neg & w_rq_nz);
    assign w_rclamp = (PROD_W'(w_rmag) > PROD_W'(cgpg_pkg::RADIUS_LIMIT)) ?
                      cgpg_pkg::RADIUS_LIMIT : RAD_W'(w_rmag);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_radius <= w_rq_neg ? -$signed(w_rclamp) : $signed(w_rclamp);
        end
    end

    cgpg_delay #(
        .WIDTH (RAD_W),
        .DEPTH (cgpg_pkg::R_DLY)
    ) u_delay_radius (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (r_radius),
        .o_data (w_radius_d)
    );

    cgpg_div #(
        .NUM_W  (cgpg_pkg::P_NUM_W),
        .DEN_W  (cgpg_pkg::P_DEN_W),
        .SIDE_W (1)
    ) u_div_phase (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (w_p_num),
        .i_den    (w_p_den),
        .i_side   (1'b0),
        .o_quo    (w_pq),
        .o_rem_nz (),
        .o_side   ()
    );

    cgpg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_pq[cgpg_pkg::PHASE_W-1:0]),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    cgpg_div #(
        .NUM_W  (cgpg_pkg::Z_NUM_W),
        .DEN_W  (cgpg_pkg::Z_DEN_W),
        .SIDE_W (1)
    ) u_div_height (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (w_z_num),
        .i_den    (w_z_den),
        .i_side   (1'b0),
        .o_quo    (w_zq),
        .o_rem_nz (),
        .o_side   ()
    );

    assign w_zsat = cgpg_pkg::sat_u24(w_zq);

    cgpg_delay #(
        .WIDTH (POS_W),
        .DEPTH (cgpg_pkg::Z_DLY)
    ) u_delay_height (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (w_zsat),
        .o_data (w_z_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= PROD_W'($signed(w_radius_d)) * PROD_W'(w_cos);
            r_py <= PROD_W'($signed(w_radius_d)) * PROD_W'(w_sin);
            r_x  <= cgpg_pkg::sat_s24((r_px + cgpg_pkg::ROUND_HALF) >>> 30);
            r_y  <= cgpg_pkg::sat_s24((r_py + cgpg_pkg::ROUND_HALF) >>> 30);
        end
    end

    assign w_last.x_pos = r_x;
    assign w_last.y_pos = r_y;
    assign w_last.z_pos = w_z_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= r_vld[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out_item <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/core/cgpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpg_front
// Two stage front end that forms the dividends and divisors of the radius,
// phase and height quotients from an index triple and the configuration.
// ----------------------------------------------------------------------------
module cgpg_front (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  cgpg_pkg::t_in_item                  i_item,
    input  cgpg_pkg::t_cfg                      i_cfg,
    output logic [cgpg_pkg::R_NUM_W-1:0]        o_r_mag,
    output logic                                o_r_neg,
    output logic [cgpg_pkg::R_DEN_W-1:0]        o_r_den,
    output logic [cgpg_pkg::P_NUM_W-1:0]        o_p_num,
    output logic [cgpg_pkg::P_DEN_W-1:0]        o_p_den,
    output logic [cgpg_pkg::Z_NUM_W-1:0]        o_z_num,
    output logic [cgpg_pkg::Z_DEN_W-1:0]        o_z_den
);

    localparam int PRD_W  = cgpg_pkg::PRD_W;
    localparam int STEP_W = cgpg_pkg::STEP_W;
    localparam int A_W    = cgpg_pkg::A_W;
    localparam int RN_W   = cgpg_pkg::R_NUM_W + 1;
    localparam int ZN_W   = cgpg_pkg::Z_NUM_W;
    localparam int CNT_W  = cgpg_pkg::CNT_W;
    localparam int CFG_W  = cgpg_pkg::CFG_W;
    localparam int FB     = cgpg_pkg::FRACTION_BITS;

    logic [PRD_W-1:0]              r_prod_in;
    logic signed [STEP_W-1:0]      r_prod_step;
    logic [PRD_W-1:0]              r_prod_z;
    logic [CNT_W-1:0]              r_rp;
    logic [CNT_W-1:0]              r_hp;
    logic [cgpg_pkg::P_NUM_W-1:0]  r_p_num1;
    logic [cgpg_pkg::P_DEN_W-1:0]  r_p_den1;

    logic signed [CFG_W:0]         w_diff;
    logic [CNT_W-1:0]              w_odd_r;
    logic [CNT_W-1:0]              w_odd_z;
    logic signed [A_W-1:0]         w_a;
    logic signed [RN_W-1:0]        w_rn;
    logic signed [RN_W-1:0]        w_rabs;
    logic [ZN_W-1:0]               w_zn;

    logic [cgpg_pkg::R_NUM_W-1:0]  r_r_mag;
    logic                          r_r_neg;
    logic [cgpg_pkg::R_DEN_W-1:0]  r_r_den;
    logic [cgpg_pkg::P_NUM_W-1:0]  r_p_num;
    logic [cgpg_pkg::P_DEN_W-1:0]  r_p_den;
    logic [ZN_W-1:0]               r_z_num;
    logic [cgpg_pkg::Z_DEN_W-1:0]  r_z_den;

    assign w_diff  = $signed({1'b0, i_cfg.outer_diameter}) - $signed({1'b0, i_cfg.inner_diameter});
    assign w_odd_r = {i_item.radial_index, 1'b1};
    assign w_odd_z = {i_item.height_index, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_in   <= PRD_W'(i_cfg.inner_diameter * i_cfg.radial_cnt);
            r_prod_step <= STEP_W'(w_diff * $signed({1'b0, w_odd_r}));
            r_prod_z    <= PRD_W'(i_cfg.cylinder_height * w_odd_z);
            r_rp        <= i_cfg.radial_cnt;
            r_hp        <= i_cfg.height_cnt;
            r_p_num1    <= {i_item.angle_index, cgpg_pkg::PHASE_W'(i_cfg.circle_cnt >> 1)};
            r_p_den1    <= i_cfg.circle_cnt;
        end
    end

    assign w_a    = $signed({2'b00, r_prod_in, 1'b0}) + A_W'(r_prod_step);
    assign w_rn   = (RN_W'(w_a) <<< FB) + $signed(RN_W'({r_rp, 1'b0}));
    assign w_rabs = w_rn[RN_W-1] ? -w_rn : w_rn;
    assign w_zn   = (ZN_W'(r_prod_z) << FB) + ZN_W'(r_hp);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r_mag <= w_rabs[RN_W-2:0];
            r_r_neg <= w_rn[RN_W-1];
            r_r_den <= {r_rp, 2'b00};
            r_p_num <= r_p_num1;
            r_p_den <= r_p_den1;
            r_z_num <= w_zn;
            r_z_den <= {r_hp, 1'b0};
        end
    end

    assign o_r_mag = r_r_mag;
    assign o_r_neg = r_r_neg;
    assign o_r_den = r_r_den;
    assign o_p_num = r_p_num;
    assign o_p_den = r_p_den;
    assign o_z_num = r_z_num;
    assign o_z_den = r_z_den;

endmodule

### rtl/core/cgpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpg_div
// Pipelined restoring divider for unsigned operands. Each stage resolves one
// quotient bit.
// ----------------------------------------------------------------------------
module cgpg_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [NUM_W-1:0]  o_quo,
    output logic              o_rem_nz,
    output logic [SIDE_W-1:0] o_side
);

    logic [NUM_W-1:0]  r_nq   [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [NUM_W-1:0]  nq_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (s == 0) begin : g_first
            assign nq_in   = i_num;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign nq_in   = r_nq[s-1];
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[s]   <= {nq_in[NUM_W-2:0], ge};
                r_rem[s]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_den[s]  <= den_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_quo    = r_nq[NUM_W-1];
    assign o_rem_nz = |r_rem[NUM_W-1];
    assign o_side   = r_side[NUM_W-1];

endmodule

### rtl/core/cgpg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpg_cordic
// Rotation mode CORDIC over a 32-bit phase word, one micro-rotation per
// stage, followed by a stage that maps the result into its quadrant.
// ----------------------------------------------------------------------------
module cgpg_cordic (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [cgpg_pkg::PHASE_W-1:0]           i_phase,
    output logic signed [cgpg_pkg::CORD_W-1:0]     o_cos,
    output logic signed [cgpg_pkg::CORD_W-1:0]     o_sin
);

    localparam int N = cgpg_pkg::CORDIC_STEPS;
    localparam int W = cgpg_pkg::CORD_W;
    localparam int PW = cgpg_pkg::PHASE_W;

    logic signed [W-1:0] r_cx   [N];
    logic signed [W-1:0] r_cy   [N];
    logic signed [W-1:0] r_z    [N];
    logic [1:0]          r_quad [N];
    logic signed [W-1:0] r_cos;
    logic signed [W-1:0] r_sin;

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic signed [W-1:0] cx_in;
        logic signed [W-1:0] cy_in;
        logic signed [W-1:0] z_in;
        logic [1:0]          q_in;
        logic signed [W-1:0] atan_s;

        if (s == 0) begin : g_first
            assign cx_in = cgpg_pkg::CORDIC_GAIN;
            assign cy_in = '0;
            assign z_in  = $signed(W'({2'b00, i_phase[PW-3:0]}));
            assign q_in  = i_phase[PW-1:PW-2];
        end else begin : g_next
            assign cx_in = r_cx[s-1];
            assign cy_in = r_cy[s-1];
            assign z_in  = r_z[s-1];
            assign q_in  = r_quad[s-1];
        end

        assign atan_s = $signed(cgpg_pkg::ATAN_TURNS[s]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[W-1]) begin
                    r_cx[s] <= cx_in - (cy_in >>> s);
                    r_cy[s] <= cy_in + (cx_in >>> s);
                    r_z[s]  <= z_in - atan_s;
                end else begin
                    r_cx[s] <= cx_in + (cy_in >>> s);
                    r_cy[s] <= cy_in - (cx_in >>> s);
                    r_z[s]  <= z_in + atan_s;
                end
                r_quad[s] <= q_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (cgpg_pkg::t_quad'(r_quad[N-1]))
                cgpg_pkg::QUAD_I: begin
                    r_cos <= r_cx[N-1];
                    r_sin <= r_cy[N-1];
                end
                cgpg_pkg::QUAD_II: begin
                    r_cos <= -r_cy[N-1];
                    r_sin <= r_cx[N-1];
                end
                cgpg_pkg::QUAD_III: begin
                    r_cos <= -r_cx[N-1];
                    r_sin <= -r_cy[N-1];
                end
                cgpg_pkg::QUAD_IV: begin
                    r_cos <= r_cy[N-1];
                    r_sin <= -r_cx[N-1];
                end
                default: begin
                    r_cos <= r_cx[N-1];
                    r_sin <= r_cy[N-1];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

### rtl/core/cgpg_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpg_delay
// Enabled register chain that keeps a side path aligned with the main
// pipeline.
// ----------------------------------------------------------------------------
module cgpg_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_data = r_pipe[DEPTH-1];

endmodule
